@@ rtl/disk_elastic_collision_response_macros.svh @@
// assertion wrappers, empty for synthesis
`ifndef DISK_ELASTIC_COLLISION_RESPONSE_MACROS_SVH
`define DISK_ELASTIC_COLLISION_RESPONSE_MACROS_SVH
`ifndef SYNTHESIS
`define DECR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DECR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DECR_ASSERT_IMP(lbl, ante, cons, msg)
`define DECR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/decr_pkg.sv @@
`default_nettype none
package decr_pkg;

  localparam int unsigned VW = 32;

  typedef enum logic [1:0] {
    OUTCOME_APPLIED    = 2'd0,
    OUTCOME_SEPARATING = 2'd1,
    OUTCOME_COINCIDENT = 2'd2
  } outcome_e;

  typedef struct packed {
    logic signed [VW-1:0] pos_a_x;
    logic signed [VW-1:0] pos_a_y;
    logic signed [VW-1:0] pos_b_x;
    logic signed [VW-1:0] pos_b_y;
    logic signed [VW-1:0] vel_a_x;
    logic signed [VW-1:0] vel_a_y;
    logic signed [VW-1:0] vel_b_x;
    logic signed [VW-1:0] vel_b_y;
    logic        [VW-1:0] mass_a;
    logic        [VW-1:0] mass_b;
  } req_t;

  typedef struct packed {
    logic signed [VW-1:0] delta_a_x;
    logic signed [VW-1:0] delta_a_y;
    logic signed [VW-1:0] delta_b_x;
    logic signed [VW-1:0] delta_b_y;
    outcome_e             outcome;
  } rsp_t;

endpackage
`default_nettype wire

@@ rtl/disk_elastic_collision_response.sv @@
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   in_req_i  (req_t)
// out       output     out_valid_o / out_stall_i out_rsp_o (rsp_t)
//
// one request per cycle while the output is not stalled; stages: difference stage, one multiplier
// stage, sum stage, two three-stage multipliers, the 34-step restoring divider,
// output register. the divider's quotient bits set the depth.
// reset clears only the valid bits of the pipeline.
// a result held on the output under stall freezes the whole pipeline and
// in_stall_o goes high in the same cycle; nothing is dropped or repeated.
`default_nettype none
`include "disk_elastic_collision_response_macros.svh"
module disk_elastic_collision_response
  import decr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned W1 = VW + 1;      // differences, magnitudes, 2m, mass sum
  localparam int unsigned W2 = 2 * VW + 2;  // squares, dot product, distance
  localparam int unsigned W3 = 3 * VW + 3;  // denominator, base
  localparam int unsigned W4 = 4 * VW + 4;  // numerators
  localparam int unsigned QW = VW + 2;

  typedef struct packed {
    logic          ndx, ndy, nwx, nwy;
    logic [W1-1:0] adx, ady, ma2, mb2, msum;
  } t1_t;

  typedef struct packed {
    logic          ndx, ndy, coin, sep;
    logic [W1-1:0] ma2, mb2;
  } t2_t;

  typedef struct packed {
    logic          ndx, ndy, coin, sep;
    logic [W3-1:0] den;
  } t3_t;

  typedef struct packed {
    logic ndx, ndy, coin, sep;
  } t4_t;

  function automatic logic [W1-1:0] mag(input logic [W1-1:0] v);
    return v[W1-1] ? (~v + W1'(1)) : v;
  endfunction

  function automatic logic [VW-1:0] sat(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] lim;
    lim = QW'(1) << (VW - 1);
    if (neg) begin
      sat = (q > lim) ? VW'(lim) : VW'(~q + QW'(1));
    end else begin
      sat = (q > lim - QW'(1)) ? VW'(lim - QW'(1)) : VW'(q);
    end
  endfunction

  logic en;
  logic out_valid_q;
  rsp_t rsp_q, rsp_d;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: differences and masses
  logic          s1_vld_q;
  t1_t           s1_q, s1_d;
  logic [W1-1:0] dx, dy, wx, wy, ma, mb;

  always_comb begin
    dx = {in_req_i.pos_b_x[VW-1], in_req_i.pos_b_x}
       - {in_req_i.pos_a_x[VW-1], in_req_i.pos_a_x};
    dy = {in_req_i.pos_b_y[VW-1], in_req_i.pos_b_y}
       - {in_req_i.pos_a_y[VW-1], in_req_i.pos_a_y};
    wx = {in_req_i.vel_a_x[VW-1], in_req_i.vel_a_x}
       - {in_req_i.vel_b_x[VW-1], in_req_i.vel_b_x};
    wy = {in_req_i.vel_a_y[VW-1], in_req_i.vel_a_y}
       - {in_req_i.vel_b_y[VW-1], in_req_i.vel_b_y};
    // zero mass counts as the smallest one
    ma = (in_req_i.mass_a == '0) ? W1'(1) : W1'(in_req_i.mass_a);
    mb = (in_req_i.mass_b == '0) ? W1'(1) : W1'(in_req_i.mass_b);
    s1_d.ndx  = dx[W1-1];
    s1_d.ndy  = dy[W1-1];
    s1_d.nwx  = wx[W1-1];
    s1_d.nwy  = wy[W1-1];
    s1_d.adx  = mag(dx);
    s1_d.ady  = mag(dy);
    s1_d.ma2  = ma << 1;
    s1_d.mb2  = mb << 1;
    s1_d.msum = ma + mb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
    end
  end

  // velocity magnitudes travel beside stage 1 so the product lanes line up
  logic [W1-1:0] awx_q, awy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      awx_q <= mag(wx);
      awy_q <= mag(wy);
    end
  end

  // squares and component products
  logic          m1_vld;
  logic [W1-1:0] m1_a [4];
  logic [W1-1:0] m1_b [4];
  logic [W2-1:0] m1_p [4];
  t1_t           m1_t;

  always_comb begin
    m1_a[0] = s1_q.adx;  m1_b[0] = s1_q.adx;
    m1_a[1] = s1_q.ady;  m1_b[1] = s1_q.ady;
    m1_a[2] = s1_q.adx;  m1_b[2] = awx_q;
    m1_a[3] = s1_q.ady;  m1_b[3] = awy_q;
  end

  decr_mul #(
    .LANES(4), .AW(W1), .BW(W1), .TW($bits(t1_t))
  ) u_mul_sq (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s1_vld_q),
    .a_i(m1_a), .b_i(m1_b), .tag_i(s1_q),
    .vld_o(m1_vld), .p_o(m1_p), .tag_o(m1_t)
  );

  // stage 2: distance squared and signed dot product
  logic          s2_vld_q;
  t2_t           s2_q, s2_d;
  logic [W2-1:0] dist_q, s_q, dist_d, s_d;
  logic [W1-1:0] s2_adx_q, s2_ady_q, s2_msum_q;
  logic          np1, np2, sneg;

  always_comb begin
    dist_d = m1_p[0] + m1_p[1];
    np1    = m1_t.ndx ^ m1_t.nwx;
    np2    = m1_t.ndy ^ m1_t.nwy;
    if (np1 == np2) begin
      s_d  = m1_p[2] + m1_p[3];
      sneg = np1;
    end else if (m1_p[2] >= m1_p[3]) begin
      s_d  = m1_p[2] - m1_p[3];
      sneg = np1;
    end else begin
      s_d  = m1_p[3] - m1_p[2];
      sneg = np2;
    end
    s2_d.ndx  = m1_t.ndx;
    s2_d.ndy  = m1_t.ndy;
    s2_d.coin = (dist_d == '0);
    s2_d.sep  = sneg && (s_d != '0);
    s2_d.ma2  = m1_t.ma2;
    s2_d.mb2  = m1_t.mb2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= m1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q      <= s2_d;
      dist_q    <= dist_d;
      s_q       <= s_d;
      s2_adx_q  <= m1_t.adx;
      s2_ady_q  <= m1_t.ady;
      s2_msum_q <= m1_t.msum;
    end
  end

  // denominator and the two bases
  logic          m2_vld;
  logic [W2-1:0] m2_a [3];
  logic [W1-1:0] m2_b [3];
  logic [W3-1:0] m2_p [3];
  t2_t           m2_t;

  always_comb begin
    m2_a[0] = dist_q;  m2_b[0] = s2_msum_q;
    m2_a[1] = s_q;     m2_b[1] = s2_adx_q;
    m2_a[2] = s_q;     m2_b[2] = s2_ady_q;
  end

  decr_mul #(
    .LANES(3), .AW(W2), .BW(W1), .TW($bits(t2_t))
  ) u_mul_base (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s2_vld_q),
    .a_i(m2_a), .b_i(m2_b), .tag_i(s2_q),
    .vld_o(m2_vld), .p_o(m2_p), .tag_o(m2_t)
  );

  // numerators: base times twice the other disk's mass
  logic          m3_vld;
  logic [W3-1:0] m3_a [4];
  logic [W1-1:0] m3_b [4];
  logic [W4-1:0] m3_p [4];
  t3_t           m3_ti, m3_t;

  always_comb begin
    m3_a[0] = m2_p[1];  m3_b[0] = m2_t.mb2;
    m3_a[1] = m2_p[1];  m3_b[1] = m2_t.ma2;
    m3_a[2] = m2_p[2];  m3_b[2] = m2_t.mb2;
    m3_a[3] = m2_p[2];  m3_b[3] = m2_t.ma2;
    m3_ti.ndx  = m2_t.ndx;
    m3_ti.ndy  = m2_t.ndy;
    m3_ti.coin = m2_t.coin;
    m3_ti.sep  = m2_t.sep;
    m3_ti.den  = m2_p[0];
  end

  decr_mul #(
    .LANES(4), .AW(W3), .BW(W1), .TW($bits(t3_t))
  ) u_mul_num (
    .clk_i, .rst_ni, .en_i(en), .vld_i(m2_vld),
    .a_i(m3_a), .b_i(m3_b), .tag_i(m3_ti),
    .vld_o(m3_vld), .p_o(m3_p), .tag_o(m3_t)
  );

  // lanes: a x, b x, a y, b y
  logic          dv_vld;
  logic [QW-1:0] dv_q [4];
  t4_t           dv_ti, dv_t;

  always_comb begin
    dv_ti.ndx  = m3_t.ndx;
    dv_ti.ndy  = m3_t.ndy;
    dv_ti.coin = m3_t.coin;
    dv_ti.sep  = m3_t.sep;
  end

  decr_div #(
    .LANES(4), .NW(W4), .DW(W3), .QW(QW), .TW($bits(t4_t))
  ) u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(m3_vld),
    .num_i(m3_p), .den_i(m3_t.den), .tag_i(dv_ti),
    .vld_o(dv_vld), .q_o(dv_q), .tag_o(dv_t)
  );

  // output register
  always_comb begin
    rsp_d.delta_a_x = sat(dv_q[0], !dv_t.ndx);
    rsp_d.delta_b_x = sat(dv_q[1], dv_t.ndx);
    rsp_d.delta_a_y = sat(dv_q[2], !dv_t.ndy);
    rsp_d.delta_b_y = sat(dv_q[3], dv_t.ndy);
    rsp_d.outcome   = OUTCOME_APPLIED;
    if (dv_t.coin || dv_t.sep) begin
      rsp_d.delta_a_x = '0;
      rsp_d.delta_b_x = '0;
      rsp_d.delta_a_y = '0;
      rsp_d.delta_b_y = '0;
      rsp_d.outcome   = dv_t.coin ? OUTCOME_COINCIDENT : OUTCOME_SEPARATING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  logic skip_chk, zero_chk, apply_chk, negx_chk;

  assign skip_chk  = out_valid_o && (out_rsp_o.outcome != OUTCOME_APPLIED);
  assign apply_chk = out_valid_o && (out_rsp_o.outcome == OUTCOME_APPLIED);
  assign zero_chk  = (out_rsp_o.delta_a_x == '0) && (out_rsp_o.delta_a_y == '0)
                  && (out_rsp_o.delta_b_x == '0) && (out_rsp_o.delta_b_y == '0);
  assign negx_chk  = out_rsp_o.delta_a_x[VW-1] && out_rsp_o.delta_b_x[VW-1];

  `DECR_ASSERT_IMP(a_no_change_zero, skip_chk, zero_chk, "nonzero deltas without collision")
  `DECR_ASSERT_IMP(a_opposite_x, apply_chk, !negx_chk, "x changes share a negative sign")
  `DECR_ASSERT_NXT(a_hold_result, in_stall_o, out_valid_o, "result lost while stalled")

endmodule
`default_nettype wire

@@ rtl/decr_mul.sv @@
`default_nettype none
// multi-lane unsigned multiplier, b taken a chunk per stage
module decr_mul #(
  parameter int unsigned LANES = 1,
  parameter int unsigned AW    = 8,
  parameter int unsigned BW    = 8,
  parameter int unsigned TW    = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [AW-1:0]    a_i [LANES],
  input  logic [BW-1:0]    b_i [LANES],
  input  logic [TW-1:0]    tag_i,
  output logic             vld_o,
  output logic [AW+BW-1:0] p_o [LANES],
  output logic [TW-1:0]    tag_o
);

  // keep each partial product near 33 x 33
  localparam int unsigned CWR = (AW >= 1089) ? 1 : 1089 / AW;
  localparam int unsigned CW  = (CWR > BW) ? BW : CWR;
  localparam int unsigned NCH = (BW + CW - 1) / CW;
  localparam int unsigned BPW = NCH * CW;
  localparam int unsigned PW  = AW + BW;

  logic [PW-1:0]  acc_q [NCH][LANES];
  logic [AW-1:0]  a_q   [NCH][LANES];
  logic [BPW-1:0] b_q   [NCH][LANES];
  logic [TW-1:0]  tag_q [NCH];
  logic           vld_q [NCH];

  for (genvar k = 0; k < NCH; k++) begin : g_st
    logic [AW-1:0]    a_in   [LANES];
    logic [BPW-1:0]   b_in   [LANES];
    logic [PW-1:0]    acc_in [LANES];
    logic [AW+CW-1:0] part   [LANES];
    logic [PW-1:0]    acc_d  [LANES];
    logic [TW-1:0]    tag_in;
    logic             vld_in;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          a_in[l]   = a_i[l];
          b_in[l]   = BPW'(b_i[l]);
          acc_in[l] = '0;
        end
        tag_in = tag_i;
        vld_in = vld_i;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          a_in[l]   = a_q[k-1][l];
          b_in[l]   = b_q[k-1][l];
          acc_in[l] = acc_q[k-1][l];
        end
        tag_in = tag_q[k-1];
        vld_in = vld_q[k-1];
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        part[l]  = a_in[l] * b_in[l][k*CW +: CW];
        acc_d[l] = acc_in[l] + (PW'(part[l]) << (k * CW));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          acc_q[k][l] <= acc_d[l];
          a_q[k][l]   <= a_in[l];
          b_q[k][l]   <= b_in[l];
        end
        tag_q[k] <= tag_in;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      p_o[l] = acc_q[NCH-1][l];
    end
  end
  assign tag_o = tag_q[NCH-1];
  assign vld_o = vld_q[NCH-1];

endmodule
`default_nettype wire

@@ rtl/decr_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per stage, lanes share the divisor
module decr_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned NW    = 16,
  parameter int unsigned DW    = 8,
  parameter int unsigned QW    = 8,
  parameter int unsigned TW    = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i [LANES],
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [QW-1:0] q_o [LANES],
  output logic [TW-1:0] tag_o
);

  // quotient must stay below 2**QW
  localparam int unsigned RW = (DW + QW > NW) ? DW + QW : NW;

  logic [RW-1:0] r_q   [QW][LANES];
  logic [QW-1:0] q_q   [QW][LANES];
  logic [DW-1:0] den_q [QW];
  logic [TW-1:0] tag_q [QW];
  logic          vld_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [RW-1:0] r_in  [LANES];
    logic [QW-1:0] q_in  [LANES];
    logic [RW-1:0] r_d   [LANES];
    logic [QW-1:0] q_d   [LANES];
    logic [DW-1:0] den_in;
    logic [RW-1:0] dsh;
    logic [TW-1:0] tag_in;
    logic          vld_in;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          r_in[l] = RW'(num_i[l]);
          q_in[l] = '0;
        end
        den_in = den_i;
        tag_in = tag_i;
        vld_in = vld_i;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          r_in[l] = r_q[k-1][l];
          q_in[l] = q_q[k-1][l];
        end
        den_in = den_q[k-1];
        tag_in = tag_q[k-1];
        vld_in = vld_q[k-1];
      end
    end

    always_comb begin
      dsh = RW'(den_in) << (QW - 1 - k);
      for (int l = 0; l < LANES; l++) begin
        r_d[l] = r_in[l];
        q_d[l] = q_in[l];
        if (r_in[l] >= dsh) begin
          r_d[l]          = r_in[l] - dsh;
          q_d[l][QW-1-k]  = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          r_q[k][l] <= r_d[l];
          q_q[k][l] <= q_d[l];
        end
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q_o[l] = q_q[QW-1][l];
    end
  end
  assign tag_o = tag_q[QW-1];
  assign vld_o = vld_q[QW-1];

endmodule
`default_nettype wire

@@ dv/disk_elastic_collision_response_tb.sv @@
`timescale 1ns / 100ps
module disk_elastic_collision_response_tb;
  import decr_pkg::*;

  localparam int unsigned LATENCY = 44;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  rsp_t expected_deltas[$];
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned responses_seen = 0;
  int unsigned outcome_count[3] = '{0, 0, 0};
  longint unsigned cycles = 0;
  bit idle_enable = 1'b1;
  int unsigned hold_off = 0;

  disk_elastic_collision_response DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i(in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o(out_rsp_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // truncated signed quotient num/den, saturated to 32 bits
  function automatic logic signed [31:0] sat_div(logic signed [199:0] num,
                                                 logic signed [199:0] den);
    logic signed [199:0] q;
    q = num / den;
    if (q > 200'sd2147483647) return 32'sh7fffffff;
    if (q < -200'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic rsp_t predict_collision(req_t r);
    rsp_t res;
    logic signed [199:0] dx, dy, wx, wy, dist_sq, dot, ma, mb, den;
    res = '0;
    dx = $signed(r.pos_b_x) - $signed(r.pos_a_x);
    dy = $signed(r.pos_b_y) - $signed(r.pos_a_y);
    wx = $signed(r.vel_a_x) - $signed(r.vel_b_x);
    wy = $signed(r.vel_a_y) - $signed(r.vel_b_y);
    dist_sq = dx * dx + dy * dy;
    if (dist_sq == 0) begin
      res.outcome = OUTCOME_COINCIDENT;
      return res;
    end
    dot = dx * wx + dy * wy;
    if (dot < 0) begin
      res.outcome = OUTCOME_SEPARATING;
      return res;
    end
    ma = (r.mass_a == 0) ? 200'sd1 : $signed({168'd0, r.mass_a});
    mb = (r.mass_b == 0) ? 200'sd1 : $signed({168'd0, r.mass_b});
    den = (ma + mb) * dist_sq;
    res.delta_a_x = sat_div(-2 * mb * dot * dx, den);
    res.delta_a_y = sat_div(-2 * mb * dot * dy, den);
    res.delta_b_x = sat_div(2 * ma * dot * dx, den);
    res.delta_b_y = sat_div(2 * ma * dot * dy, den);
    res.outcome = OUTCOME_APPLIED;
    return res;
  endfunction

  task automatic send_request(req_t r);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_req_i <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_deltas.push_back(predict_collision(r));
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  // receiver stall: random bursts, or one long hold-off
  initial begin
    int unsigned burst;
    forever begin
      @(negedge clk_i);
      if (hold_off != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_off) @(negedge clk_i);
        hold_off = 0;
        out_stall_i <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      responses_seen++;
      if (expected_deltas.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", out_rsp_o);
      end else begin
        want = expected_deltas.pop_front();
        if (want.outcome <= OUTCOME_COINCIDENT) outcome_count[want.outcome]++;
        if (out_rsp_o.delta_a_x !== want.delta_a_x || out_rsp_o.delta_a_y !== want.delta_a_y
            || out_rsp_o.delta_b_x !== want.delta_b_x
            || out_rsp_o.delta_b_y !== want.delta_b_y
            || out_rsp_o.outcome !== want.outcome) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h %h %0d got %h %h %h %h %0d",
                     want.delta_a_x, want.delta_a_y, want.delta_b_x, want.delta_b_y,
                     want.outcome, out_rsp_o.delta_a_x, out_rsp_o.delta_a_y,
                     out_rsp_o.delta_b_x, out_rsp_o.delta_b_y, out_rsp_o.outcome);
        end
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      2: return 32'h7fffffff - $urandom_range(0, 3);
      3: return 32'h80000000 + $urandom_range(0, 3);
      default: return ($urandom() >> $urandom_range(0, 31)) ^ {32{$urandom_range(0, 1) == 1}};
    endcase
  endfunction

  function automatic req_t rand_request();
    req_t r;
    r.pos_a_x = rand_value();
    r.pos_a_y = rand_value();
    r.pos_b_x = ($urandom_range(0, 15) == 0) ? r.pos_a_x : rand_value();
    r.pos_b_y = ($urandom_range(0, 15) == 0) ? r.pos_a_y : rand_value();
    r.vel_a_x = rand_value();
    r.vel_a_y = rand_value();
    r.vel_b_x = rand_value();
    r.vel_b_y = rand_value();
    case ($urandom_range(0, 4))
      0: r.mass_a = 32'd0;
      1: r.mass_a = 32'hffffffff;
      default: r.mass_a = $urandom() >> $urandom_range(0, 31);
    endcase
    case ($urandom_range(0, 4))
      0: r.mass_b = 32'd0;
      1: r.mass_b = 32'hffffffff;
      default: r.mass_b = $urandom() >> $urandom_range(0, 31);
    endcase
    return r;
  endfunction

  function automatic req_t make_request(logic [31:0] ax, ay, bx, by, vax, vay, vbx, vby,
                                        ma, mb);
    req_t r;
    r = '{ax, ay, bx, by, vax, vay, vbx, vby, ma, mb};
    return r;
  endfunction

  task automatic test_directed();
    // head-on approach, equal masses
    send_request(make_request(0, 0, 32'h10000, 0, 32'h10000, 0, 0, 0,
                              32'h10000, 32'h10000));
    // separating
    send_request(make_request(0, 0, 32'h10000, 0, -32'sh10000, 0, 0, 0,
                              32'h10000, 32'h10000));
    // coincident centres
    send_request(make_request(5, 7, 5, 7, 1, 2, 3, 4, 9, 9));
    // zero normal speed
    send_request(make_request(0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 1, 1));
    // zero masses
    send_request(make_request(0, 0, 0, 32'h10000, 0, 32'h20000, 0, 0, 0, 0));
    // extremes, saturation
    send_request(make_request(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                              32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                              32'h1, 32'hffffffff));
    send_request(make_request(32'h7fffffff, 0, 32'h80000000, 0, 32'h80000000, 0,
                              32'h7fffffff, 0, 32'hffffffff, 32'h1));
    send_request(make_request(0, 0, 1, 1, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                              32'h80000000, 32'hffffffff, 32'hffffffff));
    send_request(make_request(0, 0, 32'hffffffff, 0, 32'h80000000, 0, 0, 0, 1, 1));
    send_request(make_request(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                              32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                              32'hffffffff, 32'hffffffff));
    end_burst();
  endtask

  task automatic test_random(int unsigned n);
    repeat (n) send_request(rand_request());
    end_burst();
  endtask

  task automatic test_backpressure();
    hold_off = 3 * LATENCY;
    repeat (80) send_request(rand_request());
    end_burst();
  endtask

  task automatic test_full_rate(int unsigned n);
    idle_enable = 1'b0;
    repeat (n) send_request(rand_request());
    end_burst();
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(220);
    test_backpressure();
    test_full_rate(100);
    while (expected_deltas.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    $display("sent %0d requests, checked %0d responses", requests_sent, responses_seen);
    $display("outcomes: applied %0d, separating %0d, coincident %0d",
             outcome_count[0], outcome_count[1], outcome_count[2]);
    if (mismatches == 0 && expected_deltas.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
